// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the baud divisor search unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/ufbd_pkg.sv
// Shared widths, constants and controller/datapath interface types for the
// fractional baud divisor search unit. No dependencies.
`timescale 1ns / 1ps

package ufbd_pkg;

  localparam int CLK_W   = 28;
  localparam int BAUD_W  = 22;
  localparam int DIV_W   = 16;
  localparam int FRAC_W  = 4;
  localparam int ERR_W   = 17;
  localparam int CALC_W  = 28;

  localparam logic [CLK_W-1:0]  CLK_RESET = 28'd25000000;
  localparam logic [ERR_W-1:0]  ERR_LIMIT = 17'd100000;
  localparam logic [FRAC_W-1:0] FRAC_MAX  = 4'd15;
  localparam logic [FRAC_W-1:0] MUL_FIRST = 4'd1;
  localparam logic [DIV_W-1:0]  DL_MIN    = 16'd3;

  // Divider operand selection.
  localparam logic [1:0] SEL_SCALE = 2'd0;
  localparam logic [1:0] SEL_DL    = 2'd1;
  localparam logic [1:0] SEL_RATE  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       latch_product;
    logic       div_start;
    logic [1:0] div_sel;
    logic       latch_scaled;
    logic       latch_dl;
    logic       latch_err;
    logic       take_best;
    logic       step;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic baud_zero;
    logic dl_ok;
    logic better;
    logic err_zero;
    logic last_pair;
  } stat_t;

endpackage

// File: hw/rtl/ufbd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Generic width; used by the datapath for all three divisions of a candidate.
`timescale 1ns / 1ps

module ufbd_divider
  import ufbd_pkg::*;
#(
  parameter int W = CALC_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: hw/rtl/ufbd_datapath.sv
// Datapath of the baud divisor search: clock register, candidate counters,
// product, shared divider, rounding, error and best-so-far tracking. Uses ufbd_pkg.
`timescale 1ns / 1ps

module ufbd_datapath
  import ufbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CLK_W-1:0]  cfg_data,
  input  logic [BAUD_W-1:0] in_baud,
  input  cmd_t              cmd,
  output stat_t             st,
  output logic [DIV_W-1:0]  out_div,
  output logic [FRAC_W-1:0] out_mul,
  output logic [FRAC_W-1:0] out_add,
  output logic [ERR_W-1:0]  out_err,
  output logic              out_found
);

  logic [CLK_W-1:0]  clk_hz;
  logic [BAUD_W-1:0] baud;
  logic [FRAC_W-1:0] mul;
  logic [FRAC_W-1:0] add;
  logic [CALC_W-1:0] product;
  logic [CALC_W-1:0] scaled;
  logic [CALC_W:0]   dl;
  logic [CALC_W-1:0] err;
  logic [FRAC_W-1:0] best_mul;
  logic [FRAC_W-1:0] best_add;
  logic [DIV_W-1:0]  best_div;
  logic [ERR_W-1:0]  best_err;

  logic [CALC_W-1:0] prod_full;
  logic [FRAC_W:0]   mul_plus_add;
  logic [CALC_W-1:0] baud_ext;
  logic [CALC_W-1:0] dvd;
  logic [CALC_W-1:0] dsr;
  logic              div_done;
  logic [CALC_W-1:0] quo;
  logic [CALC_W-1:0] rem;
  logic              round_up;

  assign prod_full    = {{(CALC_W-FRAC_W){1'b0}}, mul} *
                        {{(CALC_W-CLK_W+4){1'b0}}, clk_hz[CLK_W-1:4]};
  assign mul_plus_add = {1'b0, mul} + {1'b0, add};
  assign baud_ext     = {{(CALC_W-BAUD_W){1'b0}}, baud};

  always_comb begin
    dvd = scaled;
    case (cmd.div_sel)
      SEL_SCALE: begin
        dvd = product;
        dsr = {{(CALC_W-FRAC_W-1){1'b0}}, mul_plus_add};
      end
      SEL_DL:    dsr = baud_ext;
      SEL_RATE:  dsr = {{(CALC_W-DIV_W){1'b0}}, dl[DIV_W-1:0]};
      default:   dsr = baud_ext;
    endcase
  end

  ufbd_divider #(.W(CALC_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Round to nearest; an exact half rounds down.
  assign round_up = rem > {1'b0, baud_ext[CALC_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= CLK_RESET;
    end else if (cfg_we) begin
      clk_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud     <= in_baud;
      mul      <= MUL_FIRST;
      add      <= '0;
      best_mul <= MUL_FIRST;
      best_add <= '0;
      best_div <= '0;
      best_err <= ERR_LIMIT;
    end
    if (cmd.step) begin
      if (add == FRAC_MAX) begin
        add <= '0;
        mul <= mul + 1'b1;
      end else begin
        add <= add + 1'b1;
      end
    end
    if (cmd.latch_product) begin
      product <= prod_full;
    end
    if (cmd.latch_scaled) begin
      scaled <= quo;
    end
    if (cmd.latch_dl) begin
      dl <= {1'b0, quo} + {{CALC_W{1'b0}}, round_up};
    end
    if (cmd.latch_err) begin
      err <= (quo >= baud_ext) ? quo - baud_ext : baud_ext - quo;
    end
    if (cmd.take_best) begin
      best_mul <= mul;
      best_add <= add;
      best_div <= dl[DIV_W-1:0];
      best_err <= err[ERR_W-1:0];
    end
    if (cmd.load_out) begin
      out_div   <= best_div;
      out_mul   <= best_mul;
      out_add   <= best_add;
      out_err   <= best_err;
      out_found <= best_err < ERR_LIMIT;
    end
  end

  assign st.div_done  = div_done;
  assign st.baud_zero = baud == '0;
  assign st.dl_ok     = (dl[CALC_W:DIV_W] == '0) && (dl[DIV_W-1:0] >= DL_MIN);
  assign st.better    = err < {{(CALC_W-ERR_W){1'b0}}, best_err};
  assign st.err_zero  = err == '0;
  assign st.last_pair = (mul == FRAC_MAX) && (add == FRAC_MAX);

endmodule

// File: hw/rtl/ufbd_controller.sv
// Controller state machine of the baud divisor search: sequences the candidate
// loop, the shared divider and the output register. Uses ufbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufbd_controller
  import ufbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MULT   = 4'd1;
  localparam logic [3:0] ST_DIV_S  = 4'd2;
  localparam logic [3:0] ST_WAIT_S = 4'd3;
  localparam logic [3:0] ST_DIV_Q  = 4'd4;
  localparam logic [3:0] ST_WAIT_Q = 4'd5;
  localparam logic [3:0] ST_CHECK  = 4'd6;
  localparam logic [3:0] ST_WAIT_R = 4'd7;
  localparam logic [3:0] ST_CMP    = 4'd8;
  localparam logic [3:0] ST_NEXT   = 4'd9;
  localparam logic [3:0] ST_FINISH = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_SCALE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        // A zero rate has no usable setting, so the defaults go out as they stand.
        if (st.baud_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.latch_product = 1'b1;
          state_next        = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (st.div_done) begin
          cmd.latch_scaled = 1'b1;
          state_next       = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        cmd.div_sel   = SEL_DL;
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_Q;
      end
      ST_WAIT_Q: begin
        cmd.div_sel = SEL_DL;
        if (st.div_done) begin
          cmd.latch_dl = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.dl_ok) begin
          cmd.div_sel   = SEL_RATE;
          cmd.div_start = 1'b1;
          state_next    = ST_WAIT_R;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_WAIT_R: begin
        cmd.div_sel = SEL_RATE;
        if (st.div_done) begin
          cmd.latch_err = 1'b1;
          state_next    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (st.better) begin
          cmd.take_best = 1'b1;
        end
        // The first exact match ends the search.
        state_next = (st.better && st.err_zero) ? ST_FINISH : ST_NEXT;
      end
      ST_NEXT: begin
        if (st.last_pair) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_MULT;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_out_not_overwritten, clk, rst, cmd.load_out, !out_valid || out_ready)
  `ASSERT_IMPLY(a_no_div_done_idle, clk, rst, state == ST_IDLE, !st.div_done)

endmodule

// File: hw/rtl/uart_fractional_baud_divisor_search_unit.sv
// Fractional baud divisor search: one result beat per requested rate, one rate at a time.
// A zero rate skips the search; otherwise up to 240 (M, A) pairs are tried, each with up to
// three divisions on one shared bit-serial divider (two when its divisor is out of range).
// The next rate is taken once the result has entered the output register and the unit
// is idle again; a full output register stalls it.
// Reset (rst, synchronous): idle, no result pending, clock register 25000000.
`timescale 1ns / 1ps

module uart_fractional_baud_divisor_search_unit
  import ufbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CLK_W-1:0] cfg_data,      // peripheral_clock_hz
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,       // target_baud[21:0], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [47:0]      m_tdata,       // divisor_latch[15:0], frac_mul[19:16],
                                          // frac_add[23:20], rate_error[40:24], zero pad
  output logic             m_tuser        // found
);

  cmd_t              cmd;
  stat_t             st;
  logic [DIV_W-1:0]  out_div;
  logic [FRAC_W-1:0] out_mul;
  logic [FRAC_W-1:0] out_add;
  logic [ERR_W-1:0]  out_err;
  logic              out_found;

  assign cfg_ready = 1'b1;

  ufbd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ufbd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_baud   (s_tdata[BAUD_W-1:0]),
    .cmd       (cmd),
    .st        (st),
    .out_div   (out_div),
    .out_mul   (out_mul),
    .out_add   (out_add),
    .out_err   (out_err),
    .out_found (out_found)
  );

  assign m_tdata = {7'd0, out_err, out_add, out_mul, out_div};
  assign m_tuser = out_found;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for the fractional baud divisor search unit: rate
// requests are streamed in and every result beat is checked against a
// behavioural search. Depends on ufbd_pkg and the unit's top module only.
`timescale 1ns / 1ps

module tb_top;
  import ufbd_pkg::*;

  localparam int unsigned ERR_NONE    = 100000;
  localparam int unsigned DIV_CEILING = 65536;

  // Timeout for the whole run, in clock cycles; roughly 120 rates are sent, each of
  // which may need a full search.
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  // Receiver behaviour modes.
  localparam logic [1:0] READY_ALWAYS = 2'd0;
  localparam logic [1:0] READY_SPOTTY = 2'd1;
  localparam logic [1:0] READY_HELD   = 2'd2;

  typedef struct packed {
    logic [DIV_W-1:0]  divisor;
    logic [FRAC_W-1:0] mul;
    logic [FRAC_W-1:0] add;
    logic [ERR_W-1:0]  err;
    logic              found;
  } baud_setting_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CLK_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;          // target_baud[21:0], zero pad
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [47:0]      m_tdata;               // divisor_latch[15:0], frac_mul[19:16],
                                           // frac_add[23:20], rate_error[40:24], zero pad
  logic             m_tuser;               // found

  logic [CLK_W-1:0] periph_clock_hz = CLK_RESET;
  baud_setting_t    expected_settings[$];
  int unsigned      burst_left = 0;
  int unsigned      settings_checked = 0;
  int unsigned      settings_missing = 0;
  int unsigned      clock_changes = 0;
  bit               failed = 1'b0;
  longint unsigned  cycle_count = 0;
  logic [1:0]       stall_mode = READY_ALWAYS;
  int unsigned      stall_phase_left = 0;

  uart_fractional_baud_divisor_search_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  // Searches every (M, A) pair for the divisor giving the closest rate, keeping
  // the first best pair and stopping at an exact match.
  function automatic baud_setting_t search_baud_setting(input logic [CLK_W-1:0] hz,
                                                        input logic [BAUD_W-1:0] baud);
    baud_setting_t   best;
    longint unsigned base;
    longint unsigned scaled;
    longint unsigned dl;
    longint unsigned rate;
    longint unsigned err;
    longint unsigned best_err;
    bit              exact;
    best.divisor = '0;
    best.mul     = MUL_FIRST;
    best.add     = '0;
    best_err     = ERR_NONE;
    exact        = 1'b0;
    base         = longint'(hz) >> 4;
    if (baud != 0) begin
      for (int m = 1; m <= 15 && !exact; m++) begin
        for (int a = 0; a <= 15 && !exact; a++) begin
          scaled = (m * base) / (m + a);
          dl = scaled / baud;
          // Round to nearest; a remainder of exactly half rounds down.
          if ((scaled % baud) > (baud / 2))
            dl++;
          if (dl >= 3 && dl < DIV_CEILING) begin
            rate = scaled / dl;
            err = (rate <= baud) ? (baud - rate) : (rate - baud);
            if (err < best_err) begin
              best.divisor = dl[DIV_W-1:0];
              best.mul     = m[FRAC_W-1:0];
              best.add     = a[FRAC_W-1:0];
              best_err     = err;
              exact        = (err == 0);
            end
          end
        end
      end
    end
    best.err   = best_err[ERR_W-1:0];
    best.found = (best_err < ERR_NONE);
    return best;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Result beats are compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    baud_setting_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_settings.size() == 0) begin
        $error("result beat with no request outstanding: tdata %h tuser %b", m_tdata, m_tuser);
        failed = 1'b1;
      end else begin
        want = expected_settings.pop_front();
        check_field("divisor_latch", want.divisor, m_tdata[15:0]);
        check_field("frac_mul", want.mul, m_tdata[19:16]);
        check_field("frac_add", want.add, m_tdata[23:20]);
        check_field("rate_error", want.err, m_tdata[40:24]);
        check_field("found", want.found, m_tuser);
        settings_checked++;
        if (!want.found)
          settings_missing++;
      end
    end
  end

  // The receiver alternates between always ready, randomly ready and held off.
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= 2'($urandom_range(0, 2));
      stall_phase_left <= $urandom_range(1, 40);
      m_tready         <= 1'b1;
    end else begin
      stall_phase_left <= stall_phase_left - 1;
      case (stall_mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_SPOTTY: m_tready <= 1'($urandom_range(0, 1));
        READY_HELD:   m_tready <= 1'b0;
        default:      m_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_settings.size());
      $display("status: fail");
      $finish;
    end
  end

  // Sends one rate request; the sender works in bursts with random gaps between.
  // Returns at a falling edge with tvalid still high, ready for the next beat.
  task automatic send_rate(input logic [BAUD_W-1:0] baud);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, baud};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_settings.push_back(search_baud_setting(periph_clock_hz, baud));
    burst_left--;
    @(negedge clk);
  endtask

  // The clock register is only written once every outstanding result is back.
  task automatic write_clock(input logic [CLK_W-1:0] hz);
    s_tvalid = 1'b0;
    wait (expected_settings.size() == 0);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    periph_clock_hz = hz;
    clock_changes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reset clock value: common rates, a rate too slow to reach, zero, the field's
  // top value and another rate too fast to reach.
  task automatic test_reset_clock;
    send_rate(22'd9600);
    send_rate(22'd115200);
    send_rate(22'd1);
    send_rate(22'd0);
    send_rate(22'h3FFFFF);
    send_rate(22'd4000000);
  endtask

  // Exact crystal: the search stops at the first pair; 921600 has no divisor in range.
  task automatic test_exact_rates;
    write_clock(28'd18432000);
    send_rate(22'd9600);
    send_rate(22'd115200);
    send_rate(22'd300);
    send_rate(22'd921600);
  endtask

  // Scaled clock 2001 with rate 2 leaves a remainder of exactly half.
  task automatic test_tie_rounding;
    write_clock(28'd32016);
    send_rate(22'd2);
  endtask

  task automatic test_clock_extremes;
    write_clock(28'd16);
    send_rate(22'd1);
    write_clock(28'd15);
    send_rate(22'd9600);
    write_clock(28'd200000000);
    send_rate(22'd4000000);
    send_rate(22'd3000000);
    send_rate(22'd1);
    write_clock(28'hFFFFFFF);
    send_rate(22'h3FFFFF);
    send_rate(22'd115200);
  endtask

  // Each phase writes a clock setting (14745600, then random ones) and sends a mix
  // of standard rates, jittered standard rates and rates drawn over the whole field.
  task automatic test_random_rates;
    logic [CLK_W-1:0]  hz;
    logic [BAUD_W-1:0] baud;
    int unsigned       std_rate;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: hz = 28'd14745600;
        1: hz = CLK_W'($urandom_range(1000000, 200000000));
        2: hz = CLK_W'($urandom_range(16, 2000000));
        default: hz = CLK_W'($urandom);
      endcase
      write_clock(hz);
      for (int i = 0; i < 25; i++) begin
        case ($urandom_range(0, 11))
          0: std_rate = 300;
          1: std_rate = 1200;
          2: std_rate = 2400;
          3: std_rate = 4800;
          4: std_rate = 9600;
          5: std_rate = 19200;
          6: std_rate = 38400;
          7: std_rate = 57600;
          8: std_rate = 115200;
          9: std_rate = 230400;
          10: std_rate = 460800;
          default: std_rate = 921600;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: baud = BAUD_W'(std_rate);
          6, 7: baud = BAUD_W'(std_rate + $urandom_range(0, std_rate / 20) - std_rate / 40);
          default: baud = BAUD_W'($urandom_range(1, 22'h3FFFFF));
        endcase
        send_rate(baud);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_clock();
    test_exact_rates();
    test_tie_rounding();
    test_clock_extremes();
    test_random_rates();
    s_tvalid = 1'b0;
    wait (expected_settings.size() == 0);
    repeat (40) @(posedge clk);
    $display("checked %0d divisor searches over %0d clock register writes;", settings_checked,
             clock_changes);
    $display("%0d of them had no usable setting", settings_missing);
    if (!failed)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
